// File: rtl/reverb_preset_crossfade_unit_defines.svh
// Assertion macros for the reverb preset crossfade RTL.
// Included by files that carry concurrent assertions.
`ifndef REVERB_PRESET_CROSSFADE_UNIT_DEFINES_SVH
`define REVERB_PRESET_CROSSFADE_UNIT_DEFINES_SVH
// Implication checked on every rising edge outside reset.
`define RPC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define RPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/rpc_pkg.sv
// Package for the reverb preset crossfade unit: payload types, codes, tables.
// No dependencies.
`timescale 1ns / 1ps
package rpc_pkg;
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_ZONE = 2'd1;
    localparam logic [1:0] OP_PRESET = 2'd2;
    localparam int SLOTS = 8;
    localparam logic [16:0] SETTLED = 17'd65536;
    localparam logic [23:0] RATE_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [9:0] dt_ms;
        logic [1:0] zone;
        logic [3:0] preset;
        logic [15:0] transition_ms;
    } t_in;

    typedef struct packed {
        logic [15:0] decay_time;
        logic [15:0] reflections;
        logic [15:0] late_reverb;
        logic [15:0] diffusion;
        logic [15:0] density;
        logic [15:0] room_size;
        logic [15:0] wet_dry;
        logic [15:0] hf_damping;
        logic [16:0] progress;
        logic [3:0] active_preset;
        logic [1:0] active_zone;
    } t_out;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_tgt;    // copy preset row into target
        logic snap;        // current := target
        logic div_start;   // start reciprocal
        logic div_step;    // one quotient bit
        logic set_rate;    // progress := 0, rate := quotient
        logic mul_step;    // compute step = dt*rate>>8 into register
        logic prog_add;    // progress += step, or settle
        logic par_step;    // move one parameter
        logic [2:0] idx;
    } t_cmd;

    typedef struct packed {
        logic settled;
        logic overflow;     // progress + step reaches one
    } t_sts;

    function automatic logic [15:0] preset_val(input logic [3:0] p, input logic [2:0] i);
        logic [15:0] r [0:10][0:7];
        r[0] = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
        r[1] = '{16'd2048, 16'd2048, 16'd1229, 16'd2458, 16'd1638, 16'd819, 16'd819, 16'd1638};
        r[2] = '{16'd4096, 16'd1638, 16'd2048, 16'd2867, 16'd2048, 16'd1638, 16'd1229, 16'd2048};
        r[3] = '{16'd7373, 16'd1229, 16'd2458, 16'd3277, 16'd2458, 16'd2458, 16'd1638, 16'd2048};
        r[4] = '{16'd10240, 16'd2048, 16'd2867, 16'd2048, 16'd1638, 16'd2048, 16'd2048, 16'd1229};
        r[5] = '{16'd14336, 16'd1638, 16'd3277, 16'd1638, 16'd1229, 16'd2867, 16'd2458, 16'd819};
        r[6] = '{16'd8192, 16'd2458, 16'd2048, 16'd1229, 16'd819, 16'd1229, 16'd1638, 16'd1638};
        r[7] = '{16'd16384, 16'd1229, 16'd3277, 16'd3686, 16'd3277, 16'd3686, 16'd2048, 16'd2458};
        r[8] = '{16'd6144, 16'd819, 16'd2458, 16'd3686, 16'd2867, 16'd2048, 16'd1638, 16'd3277};
        r[9] = '{16'd4915, 16'd2048, 16'd1638, 16'd2867, 16'd2048, 16'd2048, 16'd1434, 16'd1638};
        r[10] = '{16'd9011, 16'd1638, 16'd2458, 16'd2458, 16'd2048, 16'd2048, 16'd1843, 16'd1638};
        if (p > 4'd10) begin
            return 16'd0;
        end
        return r[p][i];
    endfunction

    function automatic logic [3:0] zone_preset(input logic [1:0] z);
        case (z)
            2'd0: return 4'd0;
            2'd1: return 4'd2;
            2'd2: return 4'd4;
            default: return 4'd8;
        endcase
    endfunction
endpackage

// File: rtl/reverb_preset_crossfade_unit.sv
// Zone, preset and settled-tick items go straight to done; a timed preset load
// runs a 25-step serial reciprocal; a tick: step multiply, progress, up to 8 moves.
// Throughput: one item at a time; the next is taken once the result transfer is
// handed to the output register. Synchronous active-low reset restores the
// settled, all-zero, outdoor state at once.
`timescale 1ns / 1ps
module reverb_preset_crossfade_unit #(
    parameter int PARAM_COUNT = 8,
    parameter int PRESET_COUNT = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rpc_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rpc_pkg::t_out o_data
);
    rpc_pkg::t_cmd w_cmd;
    rpc_pkg::t_sts w_sts;
    logic [3:0] w_preset, w_preset_reg;
    logic [15:0] w_time;
    logic [9:0] w_dt;
    logic [1:0] w_zone_reg;
    logic w_done, w_busy, w_free;
    logic [16*rpc_pkg::SLOTS-1:0] w_params;
    logic [16:0] w_prog;
    logic r_valid;

    assign w_free = !r_valid || !i_stall;
    assign o_stall = w_busy;
    assign o_valid = r_valid;

    rpc_ctrl #(.PRESET_COUNT(PRESET_COUNT)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_item(i_data),
        .o_busy(w_busy), .i_sts(w_sts), .o_cmd(w_cmd), .o_preset(w_preset),
        .o_time(w_time), .o_dt(w_dt), .o_preset_reg(w_preset_reg),
        .o_zone_reg(w_zone_reg), .o_done(w_done), .i_out_free(w_free)
    );

    rpc_datapath #(.PARAM_COUNT(PARAM_COUNT)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_preset(w_preset),
        .i_time(w_time), .i_dt(w_dt), .o_sts(w_sts), .o_params(w_params),
        .o_progress(w_prog)
    );

    // Output register for the result transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && w_done) begin
            o_data <= {w_params, w_prog, w_preset_reg, w_zone_reg};
        end
    end
endmodule

// File: rtl/rpc_datapath.sv
// Datapath of the reverb preset crossfade unit: state, serial divider, multiplier.
// Depends on rpc_pkg.
`timescale 1ns / 1ps
module rpc_datapath #(
    parameter int PARAM_COUNT = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rpc_pkg::t_cmd   i_cmd,
    input  logic [3:0]      i_preset,
    input  logic [15:0]     i_time,
    input  logic [9:0]      i_dt,
    output rpc_pkg::t_sts   o_sts,
    output logic [16*rpc_pkg::SLOTS-1:0] o_params,
    output logic [16:0]     o_progress
);
    logic [15:0] r_cur [rpc_pkg::SLOTS];
    logic [15:0] r_tgt [rpc_pkg::SLOTS];
    logic [16:0] r_prog;
    logic [23:0] r_rate;
    logic [16:0] r_step;
    logic [24:0] r_rem;
    logic [24:0] r_quo;
    logic [33:0] w_prod;
    logic [17:0] w_sum;
    logic [25:0] w_trial;
    logic [15:0] w_c;
    logic [15:0] w_t;
    logic [15:0] w_diff;
    logic [32:0] w_mv;

    assign w_prod = {24'd0, i_dt} * {10'd0, r_rate};
    assign w_sum = {1'b0, r_prog} + {1'b0, r_step};
    assign w_trial = {r_rem, r_quo[24]} - {10'd0, i_time};
    assign w_c = r_cur[i_cmd.idx];
    assign w_t = r_tgt[i_cmd.idx];
    assign w_diff = (w_t >= w_c) ? (w_t - w_c) : (w_c - w_t);
    assign w_mv = {17'd0, w_diff} * {16'd0, r_step};

    assign o_sts.settled = (r_prog == rpc_pkg::SETTLED);
    assign o_sts.overflow = (w_sum >= {1'b0, rpc_pkg::SETTLED});
    assign o_progress = r_prog;

    // Parameter slots beyond the configured count read zero.
    always_comb begin
        for (int i = 0; i < rpc_pkg::SLOTS; i++) begin
            o_params[16*(rpc_pkg::SLOTS-1-i) +: 16] = (i < PARAM_COUNT) ? r_cur[i] : 16'd0;
        end
    end

    // Progress and rate control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog <= rpc_pkg::SETTLED;
            r_rate <= '0;
        end else if (i_cmd.snap && i_cmd.load_tgt) begin
            r_prog <= rpc_pkg::SETTLED;
            r_rate <= '0;
        end else if (i_cmd.set_rate) begin
            r_prog <= '0;
            r_rate <= (r_quo > {1'b0, rpc_pkg::RATE_MAX}) ? rpc_pkg::RATE_MAX : r_quo[23:0];
        end else if (i_cmd.prog_add) begin
            r_prog <= o_sts.overflow ? rpc_pkg::SETTLED : w_sum[16:0];
        end
    end

    // Parameter registers; cleared at reset as the table row for none.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rpc_pkg::SLOTS; i++) begin
                r_cur[i] <= '0;
                r_tgt[i] <= '0;
            end
        end else begin
            for (int i = 0; i < rpc_pkg::SLOTS; i++) begin
                if (i_cmd.load_tgt) begin
                    r_tgt[i] <= (i < PARAM_COUNT) ? rpc_pkg::preset_val(i_preset, 3'(i)) : 16'd0;
                end
                if (i_cmd.snap && i_cmd.load_tgt) begin
                    r_cur[i] <= (i < PARAM_COUNT) ? rpc_pkg::preset_val(i_preset, 3'(i)) : 16'd0;
                end else if (i_cmd.snap) begin
                    r_cur[i] <= r_tgt[i];
                end
            end
            if (i_cmd.par_step) begin
                r_cur[i_cmd.idx] <= (w_t >= w_c) ? (w_c + w_mv[31:16]) : (w_c - w_mv[31:16]);
            end
        end
    end

    // Restoring divider of 2^24 by the time, one quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= 25'h1000000;
        end else if (i_cmd.div_step) begin
            if (!w_trial[25]) begin
                r_rem <= w_trial[24:0];
                r_quo <= {r_quo[23:0], 1'b1};
            end else begin
                r_rem <= {r_rem[23:0], r_quo[24]};
                r_quo <= {r_quo[23:0], 1'b0};
            end
        end
        if (i_cmd.mul_step) begin
            r_step <= w_prod[33:8] > 26'h1FFFF ? 17'h1FFFF : w_prod[24:8];
        end
    end
endmodule

// File: rtl/rpc_ctrl.sv
// Controller of the reverb preset crossfade unit: decodes items and sequences.
// Depends on rpc_pkg and the assertion header.
`timescale 1ns / 1ps
`include "reverb_preset_crossfade_unit_defines.svh"
module rpc_ctrl #(
    parameter int PRESET_COUNT = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  rpc_pkg::t_in  i_item,
    output logic          o_busy,
    input  rpc_pkg::t_sts i_sts,
    output rpc_pkg::t_cmd o_cmd,
    output logic [3:0]    o_preset,
    output logic [15:0]   o_time,
    output logic [9:0]    o_dt,
    output logic [3:0]    o_preset_reg,
    output logic [1:0]    o_zone_reg,
    output logic          o_done,
    input  logic          i_out_free
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV = 3'd1;
    localparam logic [2:0] S_MUL = 3'd2;
    localparam logic [2:0] S_ADD = 3'd3;
    localparam logic [2:0] S_PAR = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [3:0] r_preset_reg, n_preset_reg;
    logic [1:0] r_zone_reg, n_zone_reg;
    logic [3:0] r_p;
    logic [15:0] r_time;
    logic [9:0] r_dt;
    logic [3:0] w_p;
    logic w_load;
    logic w_take;

    assign o_busy = (r_state != S_IDLE);
    assign w_take = i_valid && !o_busy;
    assign w_p = (i_item.operation == rpc_pkg::OP_ZONE) ?
        rpc_pkg::zone_preset(i_item.zone) : i_item.preset;
    // A load happens for a changed zone or a preset item, when in range and not redundant.
    assign w_load = ((i_item.operation == rpc_pkg::OP_ZONE && i_item.zone != r_zone_reg) ||
        i_item.operation == rpc_pkg::OP_PRESET) && ({28'd0, w_p} < PRESET_COUNT) &&
        !(w_p == r_preset_reg && i_sts.settled);
    assign o_preset = w_take ? w_p : r_p;
    assign o_time = r_time;
    assign o_dt = r_dt;
    assign o_preset_reg = r_preset_reg;
    assign o_zone_reg = r_zone_reg;
    assign o_done = (r_state == S_DONE);

    // Item capture registers.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_p <= w_p;
            r_time <= i_item.transition_ms;
            r_dt <= i_item.dt_ms;
        end
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_preset_reg = r_preset_reg;
        n_zone_reg = r_zone_reg;
        o_cmd = '0;
        o_cmd.idx = r_cnt[2:0];
        case (r_state)
            S_IDLE: begin
                if (w_take) begin
                    n_state = S_DONE;
                    if (i_item.operation == rpc_pkg::OP_ZONE) begin
                        n_zone_reg = i_item.zone;
                    end
                    if (w_load) begin
                        n_preset_reg = w_p;
                        o_cmd.load_tgt = 1'b1;
                        if (i_item.transition_ms == 16'd0) begin
                            o_cmd.snap = 1'b1;
                        end else begin
                            o_cmd.div_start = 1'b1;
                            n_cnt = 5'd0;
                            n_state = S_DIV;
                        end
                    end else if (i_item.operation == rpc_pkg::OP_TICK && !i_sts.settled) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd24) begin
                    n_state = S_ADD;
                    n_cnt = 5'd31;
                end
            end
            S_MUL: begin
                o_cmd.mul_step = 1'b1;
                n_state = S_ADD;
                n_cnt = 5'd0;
            end
            S_ADD: begin
                if (r_cnt == 5'd31) begin
                    o_cmd.set_rate = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.prog_add = 1'b1;
                    o_cmd.snap = i_sts.overflow;
                    n_state = i_sts.overflow ? S_DONE : S_PAR;
                end
            end
            S_PAR: begin
                o_cmd.par_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(rpc_pkg::SLOTS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
            r_preset_reg <= '0;
            r_zone_reg <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
            r_preset_reg <= n_preset_reg;
            r_zone_reg <= n_zone_reg;
        end
    end

    `RPC_ASSERT_IMP(a_take_idle, i_clk, i_rst_n, w_take, r_state == S_IDLE)
    `RPC_ASSERT_NEXT(a_div_len, i_clk, i_rst_n, r_state == S_DIV && r_cnt == 5'd24,
        r_state == S_ADD)
    `RPC_ASSERT_IMP(a_preset_range, i_clk, i_rst_n, 1'b1, {28'd0, r_preset_reg} < PRESET_COUNT)
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the reverb preset crossfade unit.
// Depends on rpc_pkg and reverb_preset_crossfade_unit; predicts every state transfer.
`timescale 1ns / 1ps
module tb_top;
    localparam int NUM_PARAMS = 8;
    localparam int NUM_PRESETS = 11;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    rpc_pkg::t_in i_data;
    logic o_valid;
    logic i_stall;
    rpc_pkg::t_out o_data;

    // Stall pattern control shared by the test tasks.
    bit quiet_mode;
    bit hold_off;
    int fail_count;
    int idle_cycles;

    // Predicted reverb state.
    logic [15:0] mix_cur [NUM_PARAMS];
    logic [15:0] mix_tgt [NUM_PARAMS];
    logic [16:0] glide_pos;
    logic [23:0] glide_rate;
    logic [3:0] sel_preset;
    logic [1:0] sel_zone;

    rpc_pkg::t_out state_queue [$];

    reverb_preset_crossfade_unit #(
        .PARAM_COUNT(NUM_PARAMS),
        .PRESET_COUNT(NUM_PRESETS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data(i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data(o_data)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Preset table values, held here independently of the package.
    function automatic logic [15:0] preset_entry(input int p, input int k);
        logic [15:0] rows [11][8];
        rows = '{
            '{0, 0, 0, 0, 0, 0, 0, 0},
            '{2048, 2048, 1229, 2458, 1638, 819, 819, 1638},
            '{4096, 1638, 2048, 2867, 2048, 1638, 1229, 2048},
            '{7373, 1229, 2458, 3277, 2458, 2458, 1638, 2048},
            '{10240, 2048, 2867, 2048, 1638, 2048, 2048, 1229},
            '{14336, 1638, 3277, 1638, 1229, 2867, 2458, 819},
            '{8192, 2458, 2048, 1229, 819, 1229, 1638, 1638},
            '{16384, 1229, 3277, 3686, 3277, 3686, 2048, 2458},
            '{6144, 819, 2458, 3686, 2867, 2048, 1638, 3277},
            '{4915, 2048, 1638, 2867, 2048, 2048, 1434, 1638},
            '{9011, 1638, 2458, 2458, 2048, 2048, 1843, 1638}
        };
        return rows[p][k];
    endfunction

    // Load a target set, either at once or as a timed glide.
    function automatic void begin_glide(input logic [3:0] p, input logic [15:0] ms);
        logic [24:0] recip;
        if (p >= NUM_PRESETS) return;
        if (p == sel_preset && glide_pos >= rpc_pkg::SETTLED) return;
        sel_preset = p;
        for (int k = 0; k < NUM_PARAMS; k++) mix_tgt[k] = preset_entry(p, k);
        if (ms == 16'd0) begin
            glide_pos = rpc_pkg::SETTLED;
            glide_rate = '0;
            for (int k = 0; k < NUM_PARAMS; k++) mix_cur[k] = mix_tgt[k];
        end else begin
            recip = 25'(25'h1000000 / ms);
            glide_pos = '0;
            glide_rate = (recip > 25'(rpc_pkg::RATE_MAX)) ? rpc_pkg::RATE_MAX : recip[23:0];
        end
    endfunction

    // Advance the glide by one tick of dt milliseconds.
    function automatic void advance_glide(input logic [9:0] dt);
        logic [33:0] step;
        logic [34:0] sum;
        logic [49:0] move;
        if (glide_pos >= rpc_pkg::SETTLED) return;
        step = (34'(dt) * 34'(glide_rate)) >> 8;
        sum = 35'(glide_pos) + 35'(step);
        if (sum >= 35'(rpc_pkg::SETTLED)) begin
            glide_pos = rpc_pkg::SETTLED;
            for (int k = 0; k < NUM_PARAMS; k++) mix_cur[k] = mix_tgt[k];
            return;
        end
        glide_pos = sum[16:0];
        for (int k = 0; k < NUM_PARAMS; k++) begin
            if (mix_tgt[k] >= mix_cur[k]) begin
                move = (50'(mix_tgt[k] - mix_cur[k]) * 50'(step)) >> 16;
                mix_cur[k] = mix_cur[k] + move[15:0];
            end else begin
                move = (50'(mix_cur[k] - mix_tgt[k]) * 50'(step)) >> 16;
                mix_cur[k] = mix_cur[k] - move[15:0];
            end
        end
    endfunction

    // Apply one item to the predicted state and queue the resulting snapshot.
    function automatic void predict_state(input rpc_pkg::t_in it);
        rpc_pkg::t_out snap;
        case (it.operation)
            rpc_pkg::OP_TICK: advance_glide(it.dt_ms);
            rpc_pkg::OP_ZONE: begin
                if (it.zone != sel_zone) begin
                    sel_zone = it.zone;
                    begin_glide((it.zone == 2'd0) ? 4'd0 : (it.zone == 2'd1) ? 4'd2 :
                                (it.zone == 2'd2) ? 4'd4 : 4'd8, it.transition_ms);
                end
            end
            rpc_pkg::OP_PRESET: begin_glide(it.preset, it.transition_ms);
            default: ;
        endcase
        snap.decay_time = mix_cur[0];
        snap.reflections = mix_cur[1];
        snap.late_reverb = mix_cur[2];
        snap.diffusion = mix_cur[3];
        snap.density = mix_cur[4];
        snap.room_size = mix_cur[5];
        snap.wet_dry = mix_cur[6];
        snap.hf_damping = mix_cur[7];
        snap.progress = glide_pos;
        snap.active_preset = sel_preset;
        snap.active_zone = sel_zone;
        state_queue.push_back(snap);
    endfunction

    // Send one item and wait for its transfer; valid stays high until the
    // caller offers the next item or drops it.
    task automatic send_item(input rpc_pkg::t_in it);
        while (!quiet_mode && $urandom_range(99) < 7) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (o_stall);
        predict_state(it);
    endtask

    function automatic rpc_pkg::t_in make_item(input logic [1:0] op, input logic [9:0] dt,
                                               input logic [1:0] z, input logic [3:0] p,
                                               input logic [15:0] ms);
        rpc_pkg::t_in it;
        it.operation = op;
        it.dt_ms = dt;
        it.zone = z;
        it.preset = p;
        it.transition_ms = ms;
        return it;
    endfunction

    function automatic rpc_pkg::t_in random_item();
        rpc_pkg::t_in it;
        it = rpc_pkg::t_in'(34'({$urandom, $urandom}));
        return it;
    endfunction

    task automatic wait_drained();
        while (state_queue.size() != 0) @(posedge i_clk);
    endtask

    // Receiver stall pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= hold_off || (!quiet_mode && $urandom_range(99) < 7);
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge i_clk) begin
        rpc_pkg::t_out exp_s;
        if (i_rst_n && o_valid && !i_stall) begin
            if (state_queue.size() == 0) begin
                $error("unexpected result transfer %h", o_data);
                fail_count++;
            end else begin
                exp_s = state_queue.pop_front();
                if (o_data.decay_time !== exp_s.decay_time) begin
                    $error("decay_time exp %0d got %0d", exp_s.decay_time, o_data.decay_time);
                    fail_count++;
                end
                if (o_data.reflections !== exp_s.reflections) begin
                    $error("reflections exp %0d got %0d", exp_s.reflections, o_data.reflections);
                    fail_count++;
                end
                if (o_data.late_reverb !== exp_s.late_reverb) begin
                    $error("late_reverb exp %0d got %0d", exp_s.late_reverb, o_data.late_reverb);
                    fail_count++;
                end
                if (o_data.diffusion !== exp_s.diffusion) begin
                    $error("diffusion exp %0d got %0d", exp_s.diffusion, o_data.diffusion);
                    fail_count++;
                end
                if (o_data.density !== exp_s.density) begin
                    $error("density exp %0d got %0d", exp_s.density, o_data.density);
                    fail_count++;
                end
                if (o_data.room_size !== exp_s.room_size) begin
                    $error("room_size exp %0d got %0d", exp_s.room_size, o_data.room_size);
                    fail_count++;
                end
                if (o_data.wet_dry !== exp_s.wet_dry) begin
                    $error("wet_dry exp %0d got %0d", exp_s.wet_dry, o_data.wet_dry);
                    fail_count++;
                end
                if (o_data.hf_damping !== exp_s.hf_damping) begin
                    $error("hf_damping exp %0d got %0d", exp_s.hf_damping, o_data.hf_damping);
                    fail_count++;
                end
                if (o_data.progress !== exp_s.progress) begin
                    $error("progress exp %0d got %0d", exp_s.progress, o_data.progress);
                    fail_count++;
                end
                if (o_data.active_preset !== exp_s.active_preset) begin
                    $error("active_preset exp %0d got %0d", exp_s.active_preset,
                           o_data.active_preset);
                    fail_count++;
                end
                if (o_data.active_zone !== exp_s.active_zone) begin
                    $error("active_zone exp %0d got %0d", exp_s.active_zone, o_data.active_zone);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Extremes, every operation and the named special cases.
    task automatic test_directed();
        // Tick when settled, same zone, same preset settled, out of range.
        send_item(make_item(rpc_pkg::OP_TICK, 10'd1023, 2'd0, 4'd0, 16'd0));
        send_item(make_item(rpc_pkg::OP_ZONE, 10'd0, 2'd0, 4'd0, 16'd0));
        send_item(make_item(rpc_pkg::OP_PRESET, 10'd0, 2'd0, 4'd0, 16'd500));
        send_item(make_item(rpc_pkg::OP_PRESET, 10'd0, 2'd0, 4'd15, 16'd0));
        send_item(make_item(rpc_pkg::OP_PRESET, 10'd0, 2'd0, 4'd11, 16'd100));
        send_item(make_item(OP_SPARE, 10'd1023, 2'd3, 4'd7, 16'hFFFF)); // unused operation
        send_item(make_item(rpc_pkg::OP_PRESET, 10'd0, 2'd0, 4'd7, 16'd0)); // immediate
        send_item(make_item(rpc_pkg::OP_PRESET, 10'd0, 2'd0, 4'd10, 16'd1)); // fastest glide
        send_item(make_item(rpc_pkg::OP_TICK, 10'd0, 2'd0, 4'd0, 16'd0));
        send_item(make_item(rpc_pkg::OP_TICK, 10'd1, 2'd0, 4'd0, 16'd0));
        // Same preset mid glide, then the slowest glide.
        send_item(make_item(rpc_pkg::OP_PRESET, 10'd0, 2'd0, 4'd10, 16'd9));
        send_item(make_item(rpc_pkg::OP_PRESET, 10'd0, 2'd0, 4'd1, 16'hFFFF));
        for (int n = 0; n < 3; n++) begin
            send_item(make_item(rpc_pkg::OP_TICK, 10'd1023, 2'd0, 4'd0, 16'd0));
        end
        send_item(make_item(rpc_pkg::OP_ZONE, 10'd0, 2'd3, 4'd0, 16'd300));
        send_item(make_item(rpc_pkg::OP_TICK, 10'd17, 2'd0, 4'd0, 16'd0));
        send_item(make_item(rpc_pkg::OP_ZONE, 10'd0, 2'd2, 4'd0, 16'd0));
        send_item(make_item(rpc_pkg::OP_ZONE, 10'd0, 2'd1, 4'd0, 16'd40));
        send_item(make_item(rpc_pkg::OP_ZONE, 10'd0, 2'd0, 4'd0, 16'd40));
        send_item(make_item(rpc_pkg::OP_TICK, 10'd1023, 2'd0, 4'd0, 16'd0));
        send_item(make_item(rpc_pkg::OP_PRESET, 10'd0, 2'd0, 4'd0, 16'd0));
        i_valid <= 1'b0;
        wait_drained();
    endtask

    // Glides with random content: a load followed by a run of ticks.
    task automatic test_random_glides(input int count);
        rpc_pkg::t_in it;
        int sent;
        sent = 0;
        while (sent < count) begin
            it = random_item();
            if ($urandom_range(9) < 8) begin
                it.operation = ($urandom_range(2) == 0) ? rpc_pkg::OP_ZONE : rpc_pkg::OP_PRESET;
                it.preset = 4'($urandom_range(NUM_PRESETS - 1));
                if ($urandom_range(3) == 0) it.preset = 4'($urandom);
                if ($urandom_range(4) == 0) it.transition_ms = 16'($urandom_range(3));
                else if ($urandom_range(1) == 0) it.transition_ms = 16'($urandom_range(2000));
                send_item(it);
                sent++;
                for (int n = $urandom_range(12); n > 0 && sent < count; n--) begin
                    it = random_item();
                    it.operation = rpc_pkg::OP_TICK;
                    if ($urandom_range(1) == 0) it.dt_ms = 10'($urandom_range(40));
                    send_item(it);
                    sent++;
                end
            end else begin
                send_item(it);
                sent++;
            end
        end
        i_valid <= 1'b0;
        wait_drained();
    endtask

    // Receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        int n;
        fork
            begin
                hold_off = 1'b1;
                n = 0;
                while (n < 200) begin
                    @(posedge i_clk);
                    n++;
                end
                hold_off = 1'b0;
            end
            begin
                for (int k = 0; k < 40; k++) send_item(random_item());
                i_valid <= 1'b0;
            end
        join
        wait_drained();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        quiet_mode = 1'b0;
        hold_off = 1'b0;
        fail_count = 0;
        sel_zone = '0;
        sel_preset = '0;
        glide_pos = rpc_pkg::SETTLED;
        glide_rate = '0;
        for (int k = 0; k < NUM_PARAMS; k++) begin
            mix_cur[k] = '0;
            mix_tgt[k] = '0;
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_glides(700);
        test_backpressure();
        quiet_mode = 1'b1;
        test_random_glides(300);
        quiet_mode = 1'b0;
        test_random_glides(700);

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
